>>> hdl/fsp_pkg.sv
package fsp_pkg;

	localparam int ARG_BITS_DEF   = 32;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_A_LO    = 8'h61;
	localparam logic [7:0] CH_D_LO    = 8'h64;
	localparam logic [7:0] CH_X_LO    = 8'h78;
	localparam logic [7:0] CH_X_UP    = 8'h58;

	// controller to datapath
	typedef struct packed {
		logic take;        // latch the format byte
		logic load_dec;    // load magnitude for decimal conversion
		logic load_hex;    // load nibbles for hex conversion
		logic dabble;      // one shift-add-3 step
		logic skip;        // drop a leading zero digit
		logic emit_char;   // emit the latched byte as the last item
		logic emit_minus;  // emit the sign
		logic emit_digit;  // emit the top digit
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic can_load;    // output register free this cycle
		logic neg;         // decimal argument was negative
		logic dab_last;    // final dabble step
		logic rem_one;     // one digit left
		logic top_zero;    // top digit is zero
	} sts_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] w;
		w = {4'h0, d};
		if (d < 4'd10) begin
			return CH_ZERO + w;
		end else begin
			return CH_A_LO + w - 8'd10;
		end
	endfunction

endpackage

>>> hdl/format_string_integer_printer.sv
// Channel   Handshake              Payload
// input     in_valid / in_stall    format_char, argument_value
// output    out_valid / out_stall  out_char, last_of_run, char_count
//
// One item at a time; in_stall is high until the current item's last result is in the
// output register. A lone percent arms a conversion; an echoed byte goes through the echo state.
// Hex loads NDIG nibbles, NDIG being the wider of the decimal and hex digit counts (10 at
// 32 bits); leading zeros are dropped one per cycle before the digits are emitted.
// Decimal runs ARG_BITS double-dabble steps, then the sign if negative, then the 10 digit
// slots at 32 bits, with leading zeros dropped the same way.
// Reset clears the pending flag, the running count and the output valid flag.
// A stalled output holds its item; the block waits on it before emitting the next one.
module format_string_integer_printer #(
	parameter int ARG_BITS   = fsp_pkg::ARG_BITS_DEF,
	parameter int COUNT_BITS = fsp_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            format_char,
	input  logic [ARG_BITS-1:0]   argument_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_char,
	output logic                  last_of_run,
	output logic [COUNT_BITS-1:0] char_count
);
	import fsp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	fsp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.format_char (format_char),
		.sts         (sts),
		.in_stall    (in_stall),
		.cmd         (cmd)
	);

	fsp_dpath #(
		.ARG_BITS   (ARG_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.format_char    (format_char),
		.argument_value (argument_value),
		.out_stall      (out_stall),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_char       (out_char),
		.last_of_run    (last_of_run),
		.char_count     (char_count)
	);

	a_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_char, cmd.emit_minus, cmd.emit_digit}))
		else $error("more than one emit source");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_char || cmd.emit_minus || cmd.emit_digit) |-> sts.can_load)
		else $error("emit into an occupied output register");

	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !(cmd.emit_char || cmd.emit_minus || cmd.emit_digit
			|| cmd.dabble || cmd.skip))
		else $error("datapath busy while an item is accepted");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.emit_char || cmd.emit_minus || cmd.emit_digit))
		else $error("output valid without an emit");

endmodule

>>> hdl/fsp_ctrl.sv
module fsp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [7:0]     format_char,
	input  fsp_pkg::sts_t  sts,
	output logic           in_stall,
	output fsp_pkg::cmd_t  cmd
);
	import fsp_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_ECHO   = 6'b000010,
		S_DABBLE = 6'b000100,
		S_SIGN   = 6'b001000,
		S_SKIP   = 6'b010000,
		S_EMIT   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   pending_q, pending_d;
	logic   accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	always_comb begin
		state_d   = state_q;
		pending_d = pending_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.take = 1'b1;
					if (pending_q) begin
						pending_d = 1'b0;
						if (format_char == CH_D_LO) begin
							cmd.load_dec = 1'b1;
							state_d      = S_DABBLE;
						end else if (format_char == CH_X_LO || format_char == CH_X_UP) begin
							cmd.load_hex = 1'b1;
							state_d      = S_SKIP;
						end else begin
							// a doubled percent and an unknown conversion both echo the byte
							state_d = S_ECHO;
						end
					end else if (format_char == CH_PERCENT) begin
						pending_d = 1'b1;
					end else begin
						state_d = S_ECHO;
					end
				end
			end
			S_ECHO: begin
				if (sts.can_load) begin
					cmd.emit_char = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_DABBLE: begin
				cmd.dabble = 1'b1;
				if (sts.dab_last) begin
					state_d = sts.neg ? S_SIGN : S_SKIP;
				end
			end
			S_SIGN: begin
				if (sts.can_load) begin
					cmd.emit_minus = 1'b1;
					state_d        = S_SKIP;
				end
			end
			S_SKIP: begin
				if (sts.top_zero && !sts.rem_one) begin
					cmd.skip = 1'b1;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.can_load) begin
					cmd.emit_digit = 1'b1;
					if (sts.rem_one) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pending_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			pending_q <= pending_d;
		end
	end

endmodule

>>> hdl/fsp_dpath.sv
module fsp_dpath #(
	parameter int ARG_BITS   = fsp_pkg::ARG_BITS_DEF,
	parameter int COUNT_BITS = fsp_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fsp_pkg::cmd_t         cmd,
	input  logic [7:0]            format_char,
	input  logic [ARG_BITS-1:0]   argument_value,
	input  logic                  out_stall,
	output fsp_pkg::sts_t         sts,
	output logic                  out_valid,
	output logic [7:0]            out_char,
	output logic                  last_of_run,
	output logic [COUNT_BITS-1:0] char_count
);
	import fsp_pkg::*;

	localparam int NDEC = (ARG_BITS * 302) / 1000 + 1;
	localparam int NHEX = (ARG_BITS + 3) / 4;
	localparam int NDIG = (NDEC > NHEX) ? NDEC : NHEX;
	localparam int DW   = NDIG * 4;
	localparam int DCW  = $clog2(ARG_BITS + 1);
	localparam int RW   = $clog2(NDIG + 1);

	logic [7:0]            char_q;
	logic [ARG_BITS-1:0]   bin_q;
	logic [DW-1:0]         dig_q;
	logic [DW-1:0]         adj;
	logic [DCW-1:0]        dab_cnt_q;
	logic [RW-1:0]         rem_q;
	logic                  neg_q;
	logic [COUNT_BITS-1:0] count_q, count_nx;
	logic                  out_valid_q;
	logic [7:0]            out_char_q;
	logic                  out_last_q;
	logic [COUNT_BITS-1:0] out_count_q;
	logic                  emit;
	logic                  arg_neg;
	logic [3:0]            top;

	assign top     = dig_q[DW-1 -: 4];
	assign arg_neg = argument_value[ARG_BITS-1];
	assign emit    = cmd.emit_char || cmd.emit_minus || cmd.emit_digit;

	assign sts.can_load = !out_valid_q || !out_stall;
	assign sts.neg      = neg_q;
	assign sts.dab_last = (dab_cnt_q == DCW'(1));
	assign sts.rem_one  = (rem_q == RW'(1));
	assign sts.top_zero = (top == 4'd0);

	// add 3 to every BCD digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[4*i +: 4] = (dig_q[4*i +: 4] >= 4'd5) ? dig_q[4*i +: 4] + 4'd3
			                                         : dig_q[4*i +: 4];
		end
	end

	assign count_nx = (count_q == {COUNT_BITS{1'b1}}) ? count_q : count_q + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			char_q <= format_char;
		end
		if (cmd.load_dec) begin
			// the most negative value negates to itself, which is its magnitude
			bin_q     <= arg_neg ? (~argument_value + 1'b1) : argument_value;
			neg_q     <= arg_neg;
			dig_q     <= '0;
			dab_cnt_q <= DCW'(ARG_BITS);
			rem_q     <= RW'(NDIG);
		end else if (cmd.load_hex) begin
			dig_q <= DW'(argument_value);
			rem_q <= RW'(NDIG);
			neg_q <= 1'b0;
		end else if (cmd.dabble) begin
			dig_q     <= {adj[DW-2:0], bin_q[ARG_BITS-1]};
			bin_q     <= {bin_q[ARG_BITS-2:0], 1'b0};
			dab_cnt_q <= dab_cnt_q - 1'b1;
		end else if (cmd.skip || cmd.emit_digit) begin
			dig_q <= {dig_q[DW-5:0], 4'h0};
			rem_q <= rem_q - 1'b1;
		end
		if (emit) begin
			out_count_q <= count_nx;
			if (cmd.emit_char) begin
				out_char_q <= char_q;
				out_last_q <= 1'b1;
			end else if (cmd.emit_minus) begin
				out_char_q <= CH_MINUS;
				out_last_q <= 1'b0;
			end else begin
				out_char_q <= digit_char(top);
				out_last_q <= sts.rem_one;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				count_q     <= count_nx;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign last_of_run = out_last_q;
	assign char_count  = out_count_q;

endmodule
